FILE: design/gb3_pkg.sv
`default_nettype none

package gb3_pkg;

    localparam int SMP_W  = 16;
    localparam int CHAN_N = 3;
    localparam int PIX_W  = SMP_W * CHAN_N;
    localparam int TAP_N  = 9;
    localparam int PROD_W = 2 * SMP_W - 1;
    localparam int W_W    = 15;
    localparam int FW_W   = 13;
    localparam int FH_W   = 16;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam int GB3_MAX_WIDTH = 4096;

    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_WEIGHT_CENTER = 3'd2;
    localparam logic [2:0] REG_WEIGHT_EDGE   = 3'd3;
    localparam logic [2:0] REG_WEIGHT_CORNER = 3'd4;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = 13'd4096;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = 16'd1024;
    localparam logic [W_W-1:0]  WEIGHT_CENTER_RST = 15'd19211;
    localparam logic [W_W-1:0]  WEIGHT_EDGE_RST   = 15'd8850;
    localparam logic [W_W-1:0]  WEIGHT_CORNER_RST = 15'd4707;

    // taps indexed row * 3 + column, row 0 on top, column 0 on the left
    typedef logic [TAP_N-1:0][SMP_W-1:0] taps_t;

    // one window column, index 0 top, 1 middle, 2 bottom
    typedef logic [2:0][PIX_W-1:0] col_t;

    typedef struct packed {
        logic drain;
        logic first_col;
        logic last_col;
        logic emit_ok;
        logic top_dup;
        logic fwd;
    } win_ctrl_t;

    typedef struct packed {
        logic valid;
        logic run_last;
        logic frame_end;
    } side_t;

    function automatic logic [SMP_W-1:0] half_add(input logic [SMP_W-1:0] a,
                                                   input logic [SMP_W-1:0] b);
        logic [SMP_W:0] s;
        s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
        return s[SMP_W:1];
    endfunction

    // doubled product plus half, floor shift by SMP_W, clip to SMP_W bits
    function automatic logic [SMP_W-1:0] round_sat(input logic [PROD_W-1:0] p);
        logic [2*SMP_W:0] t;
        logic [SMP_W:0]   q;
        t = {p[PROD_W-1], p, 1'b0} + ((2*SMP_W+1)'(1) << (SMP_W - 1));
        q = t[2*SMP_W:SMP_W];
        if (!q[SMP_W] && q[SMP_W-1]) begin
            return {1'b0, {(SMP_W-1){1'b1}}};
        end else if (q[SMP_W] && !q[SMP_W-1]) begin
            return {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            return q[SMP_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/gb3_chan_filter.sv
`default_nettype none

module gb3_chan_filter (
    input  logic                        aclk,
    input  logic                        en,
    input  gb3_pkg::taps_t              taps,
    input  logic [gb3_pkg::W_W-1:0]     wgt_center,
    input  logic [gb3_pkg::W_W-1:0]     wgt_edge,
    input  logic [gb3_pkg::W_W-1:0]     wgt_corner,
    output logic [gb3_pkg::SMP_W-1:0]   filtered
);
    import gb3_pkg::*;

    taps_t                      tap_reg;
    logic [3:0][SMP_W-1:0]      pair_reg;
    logic [SMP_W-1:0]           ctr1_reg;
    logic [SMP_W-1:0]           ctr2_reg;
    logic [SMP_W-1:0]           edge_reg;
    logic [SMP_W-1:0]           corner_reg;
    logic [2:0][PROD_W-1:0]     prod_reg;
    logic [SMP_W-1:0]           out_reg;

    logic signed [2*SMP_W-1:0]  mul_ctr;
    logic signed [2*SMP_W-1:0]  mul_edge;
    logic signed [2*SMP_W-1:0]  mul_corner;

    assign mul_ctr    = $signed(ctr2_reg) * $signed({1'b0, wgt_center});
    assign mul_edge   = $signed(edge_reg) * $signed({1'b0, wgt_edge});
    assign mul_corner = $signed(corner_reg) * $signed({1'b0, wgt_corner});

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg     <= taps;
            pair_reg[0] <= half_add(tap_reg[1], tap_reg[7]);
            pair_reg[1] <= half_add(tap_reg[3], tap_reg[5]);
            pair_reg[2] <= half_add(tap_reg[0], tap_reg[8]);
            pair_reg[3] <= half_add(tap_reg[2], tap_reg[6]);
            ctr1_reg    <= tap_reg[4];
            edge_reg    <= half_add(pair_reg[0], pair_reg[1]);
            corner_reg  <= half_add(pair_reg[2], pair_reg[3]);
            ctr2_reg    <= ctr1_reg;
            prod_reg[0] <= mul_ctr[PROD_W-1:0];
            prod_reg[1] <= mul_edge[PROD_W-1:0];
            prod_reg[2] <= mul_corner[PROD_W-1:0];
            out_reg     <= round_sat(prod_reg[0]) + round_sat(prod_reg[1])
                         + round_sat(prod_reg[2]);
        end
    end

    assign filtered = out_reg;

endmodule

`default_nettype wire

FILE: design/gaborish_3x3_fixed_point_smoother_top.sv
// Output path: a word leaves on m_tdata after the window stage and the filter's tap,
// pair, sum, product and output registers, which stall while a result waits on m_tready.
// Throughput: one input word per cycle unless the output stalls; a word that ends
// a row with two result words holds s_tready low until the single window stage
// has sent its first result. Reset: synchronous on aresetn low; clears counters,
// valids and config registers. Line stores are not cleared and need no clearing pass.
`default_nettype none

module gaborish_3x3_fixed_point_smoother_top #(
    parameter int MAX_WIDTH = gb3_pkg::GB3_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gb3_pkg::PIX_W-1:0]    s_tdata,   // sample_x, sample_y, sample_b
    input  logic                         s_tuser,   // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gb3_pkg::PIX_W-1:0]    m_tdata,   // filtered_x, filtered_y, filtered_b
    output logic                         m_tlast,   // frame_end
    output logic                         m_tuser,   // run_last
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gb3_pkg::APB_AW-1:0]   paddr,
    input  logic [gb3_pkg::APB_DW-1:0]   pwdata,
    output logic [gb3_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import gb3_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [16:0]   MAXW      = 17'(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [W_W-1:0]  wgt_center_reg;
    logic [W_W-1:0]  wgt_edge_reg;
    logic [W_W-1:0]  wgt_corner_reg;
    logic            cfg_wr;
    logic [2:0]      reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg         <= FRAME_WIDTH_RST;
            fh_reg         <= FRAME_HEIGHT_RST;
            wgt_center_reg <= WEIGHT_CENTER_RST;
            wgt_edge_reg   <= WEIGHT_EDGE_RST;
            wgt_corner_reg <= WEIGHT_CORNER_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_FRAME_WIDTH:   fw_reg         <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT:  fh_reg         <= pwdata[FH_W-1:0];
                REG_WEIGHT_CENTER: wgt_center_reg <= pwdata[W_W-1:0];
                REG_WEIGHT_EDGE:   wgt_edge_reg   <= pwdata[W_W-1:0];
                REG_WEIGHT_CORNER: wgt_corner_reg <= pwdata[W_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FRAME_WIDTH:   prdata = APB_DW'(fw_reg);
            REG_FRAME_HEIGHT:  prdata = APB_DW'(fh_reg);
            REG_WEIGHT_CENTER: prdata = APB_DW'(wgt_center_reg);
            REG_WEIGHT_EDGE:   prdata = APB_DW'(wgt_edge_reg);
            REG_WEIGHT_CORNER: prdata = APB_DW'(wgt_corner_reg);
            default:           prdata = '0;
        endcase
    end

    logic [AW-1:0]   col_reg, col_next;
    logic [FH_W-1:0] row_reg, row_next;
    logic [16:0]     fw_ext;
    logic [AW-1:0]   wm1;
    logic [AW-1:0]   c_eff;
    logic [FH_W-1:0] h_eff;
    logic            drain;
    logic            last;
    logic            ignore;
    logic            s_fire;
    logic            load;

    logic            b_valid_reg, b_valid_next;
    win_ctrl_t       b_ctrl_reg, b_ctrl_next;
    logic            ph_reg, ph_next;
    logic [AW-1:0]   b_addr_reg;
    logic [PIX_W-1:0] b_smp_reg;
    logic            two_ph;
    logic            adv;
    logic            step;
    logic            b_done;
    logic            fwd;

    side_t [4:0]     side_reg, side_next;

    assign fw_ext = {4'b0, fw_reg};

    always_comb begin
        if (fw_reg == '0) begin
            wm1 = '0;
        end else if (fw_ext > MAXW) begin
            wm1 = LAST_ADDR;
        end else begin
            wm1 = AW'(fw_ext - 17'd1);
        end
    end

    assign c_eff  = (col_reg > wm1) ? wm1 : col_reg;
    assign h_eff  = (fh_reg == '0) ? FH_W'(1) : fh_reg;
    assign drain  = row_reg >= h_eff;
    assign last   = c_eff == wm1;
    assign ignore = s_tuser & ~drain;
    assign s_fire = s_tvalid & s_tready;
    assign load   = s_fire & ~ignore;

    assign two_ph   = ~b_ctrl_reg.first_col & b_ctrl_reg.last_col & b_ctrl_reg.emit_ok;
    assign adv      = ~side_reg[4].valid | m_tready;
    assign step     = adv & b_valid_reg;
    assign b_done   = step & (~two_ph | ph_reg);
    assign s_tready = adv & ~(b_valid_reg & two_ph & ~ph_reg);
    assign fwd      = b_valid_reg & ~b_ctrl_reg.drain & (b_addr_reg == c_eff);

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        b_ctrl_next  = b_ctrl_reg;
        b_valid_next = load | (b_valid_reg & ~b_done);
        ph_next      = step ? (two_ph & ~ph_reg) : ph_reg;
        if (load) begin
            col_next = last ? '0 : c_eff + AW'(1);
            if (last) begin
                row_next = drain ? '0 : row_reg + FH_W'(1);
            end
            b_ctrl_next.drain     = drain;
            b_ctrl_next.first_col = c_eff == '0;
            b_ctrl_next.last_col  = last;
            b_ctrl_next.emit_ok   = row_reg != '0;
            b_ctrl_next.top_dup   = row_reg <= FH_W'(1);
            b_ctrl_next.fwd       = fwd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            b_ctrl_reg  <= '0;
            ph_reg      <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= b_valid_next;
            b_ctrl_reg  <= b_ctrl_next;
            ph_reg      <= ph_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            b_addr_reg <= c_eff;
            b_smp_reg  <= s_tdata;
        end
    end

    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_rd_reg;
    logic [PIX_W-1:0] older_rd_reg;
    logic [PIX_W-1:0] fwd_mid_reg;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] bot;

    always_ff @(posedge aclk) begin
        if (load) begin
            newer_rd_reg <= newer_mem[c_eff];
        end
        if (load && !drain) begin
            newer_mem[c_eff] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            older_rd_reg <= older_mem[c_eff];
        end
        if (b_done && !b_ctrl_reg.drain) begin
            older_mem[b_addr_reg] <= mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_done) begin
            fwd_mid_reg <= mid;
        end
    end

    col_t            col;
    col_t [2:0]      win_reg, win_next, ewin;
    logic            emit;
    logic            run_last;
    logic            frame_end;
    taps_t           tap_in [CHAN_N];

    assign mid = newer_rd_reg;
    assign top = b_ctrl_reg.top_dup ? mid : (b_ctrl_reg.fwd ? fwd_mid_reg : older_rd_reg);
    assign bot = b_ctrl_reg.drain ? mid : b_smp_reg;
    assign col = {bot, mid, top};

    always_comb begin
        ewin[0] = b_ctrl_reg.first_col ? col : win_reg[1];
        ewin[1] = b_ctrl_reg.first_col ? col : win_reg[2];
        ewin[2] = col;
        // shift twice at a row end that emits nothing
        if (!b_ctrl_reg.first_col && b_ctrl_reg.last_col && !b_ctrl_reg.emit_ok) begin
            win_next = {col, col, win_reg[2]};
        end else begin
            win_next = ewin;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            win_reg <= win_next;
        end
    end

    assign emit      = b_ctrl_reg.emit_ok & (~b_ctrl_reg.first_col | b_ctrl_reg.last_col);
    assign run_last  = b_ctrl_reg.first_col | ~b_ctrl_reg.last_col | ph_reg;
    assign frame_end = b_ctrl_reg.drain & b_ctrl_reg.last_col & run_last;

    always_comb begin
        for (int ch = 0; ch < CHAN_N; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int cc = 0; cc < 3; cc++) begin
                    tap_in[ch][r*3+cc] = ewin[cc][r][ch*SMP_W +: SMP_W];
                end
            end
        end
    end

    always_comb begin
        side_next = side_reg;
        if (adv) begin
            side_next[0].valid     = step & emit;
            side_next[0].run_last  = run_last;
            side_next[0].frame_end = frame_end;
            for (int i = 1; i < 5; i++) begin
                side_next[i] = side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else begin
            side_reg <= side_next;
        end
    end

    logic [CHAN_N-1:0][SMP_W-1:0] filt;

    for (genvar ch = 0; ch < CHAN_N; ch++) begin : g_chan
        gb3_chan_filter u_filt (
            .aclk       (aclk),
            .en         (adv),
            .taps       (tap_in[ch]),
            .wgt_center (wgt_center_reg),
            .wgt_edge   (wgt_edge_reg),
            .wgt_corner (wgt_corner_reg),
            .filtered   (filt[ch])
        );
    end

    assign m_tvalid = side_reg[4].valid;
    assign m_tdata  = filt;
    assign m_tlast  = side_reg[4].frame_end;
    assign m_tuser  = side_reg[4].run_last;

    a_phase_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        ph_reg |-> (b_valid_reg && two_ph))
        else $error("second phase without a two-word item in the window stage");

    a_second_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && ph_reg && adv) |=> (side_reg[0].valid && side_reg[0].run_last))
        else $error("second word of a row end did not enter the filter");

    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("frame end on a word that is not the last of its item");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gb3_pkg::*;

    localparam logic CMD_PIXEL    = 1'b0;
    localparam logic CMD_DRAIN    = 1'b1;
    localparam int   SETTLE       = 12;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   RANDOM_WORDS = 380;
    localparam int   PRINT_CAP    = 100;

    typedef struct {
        logic [SMP_W-1:0] fx;
        logic [SMP_W-1:0] fy;
        logic [SMP_W-1:0] fb;
        logic             frame_end;
        logic             run_last;
    } smooth_px_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata  = '0;   // sample_x, sample_y, sample_b
    logic              s_tuser  = 1'b0; // cmd
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [PIX_W-1:0]  m_tdata;         // filtered_x, filtered_y, filtered_b
    logic              m_tlast;         // frame_end
    logic              m_tuser;         // run_last
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    gaborish_3x3_fixed_point_smoother_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    logic [FW_W-1:0]  cfg_width;
    logic [FH_W-1:0]  cfg_height;
    logic [W_W-1:0]   cfg_center;
    logic [W_W-1:0]   cfg_edge;
    logic [W_W-1:0]   cfg_corner;
    logic [PIX_W-1:0] older_line [GB3_MAX_WIDTH];
    logic [PIX_W-1:0] newer_line [GB3_MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];   // [column][row]
    int               col_count;
    int               row_count;
    smooth_px_t       expected_px [$];
    int               words_in;
    int               words_sent = 0;
    int               errors     = 0;
    int               cycles     = 0;
    bit               send_calm  = 1'b0;
    bit               take_calm  = 1'b0;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [SMP_W-1:0] got,
                               input logic [SMP_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic int halve(input int a, input int b);
        return (a + b) >>> 1;
    endfunction

    function automatic int q15_mul(input int a, input logic [W_W-1:0] w);
        longint p;
        p = (2 * longint'(a) * longint'(w) + 32768) >>> 16;
        if (p > 32767) begin
            p = 32767;
        end
        if (p < -32768) begin
            p = -32768;
        end
        return int'(p);
    endfunction

    function automatic logic [SMP_W-1:0] blend_lane(input int lane);
        int p [3][3];
        int total;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p[i][j] = int'($signed(win[i][j][lane*SMP_W +: SMP_W]));
            end
        end
        total = q15_mul(p[1][1], cfg_center)
              + q15_mul(halve(halve(p[1][0], p[1][2]), halve(p[0][1], p[2][1])), cfg_edge)
              + q15_mul(halve(halve(p[0][0], p[2][2]), halve(p[2][0], p[0][2])), cfg_corner);
        return total[SMP_W-1:0];
    endfunction

    function automatic smooth_px_t window_result(input logic frame_end);
        smooth_px_t px;
        px.fx        = blend_lane(0);
        px.fy        = blend_lane(1);
        px.fb        = blend_lane(2);
        px.frame_end = frame_end;
        px.run_last  = 1'b0;
        return px;
    endfunction

    task automatic smooth_step(input logic cmd, input logic [PIX_W-1:0] smp);
        int               w;
        int               h;
        int               c;
        int               r;
        int               n;
        logic             drain;
        logic [PIX_W-1:0] cur [3];
        smooth_px_t       first_px;
        smooth_px_t       second_px;
        w = int'(cfg_width);
        if (w < 1) begin
            w = 1;
        end
        if (w > GB3_MAX_WIDTH) begin
            w = GB3_MAX_WIDTH;
        end
        h = (cfg_height == 0) ? 1 : int'(cfg_height);
        c = (col_count > w - 1) ? w - 1 : col_count;
        r = row_count;
        n = 0;
        drain = (r >= h);
        if (cmd == CMD_DRAIN && !drain) begin
            return;
        end
        cur[1] = newer_line[c];
        cur[0] = (r <= 1) ? newer_line[c] : older_line[c];
        cur[2] = drain ? newer_line[c] : smp;
        if (!drain) begin
            older_line[c] = newer_line[c];
            newer_line[c] = smp;
        end
        if (c == 0) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win[k][j] = cur[j];
                end
            end
        end else begin
            for (int j = 0; j < 3; j++) begin
                win[0][j] = win[1][j];
                win[1][j] = win[2][j];
                win[2][j] = cur[j];
            end
            if (r >= 1) begin
                first_px = window_result(1'b0);
                n = 1;
            end
        end
        if (c >= w - 1) begin
            if (c >= 1) begin
                for (int j = 0; j < 3; j++) begin
                    win[0][j] = win[1][j];
                    win[1][j] = win[2][j];
                end
            end
            if (r >= 1) begin
                if (n == 0) begin
                    first_px = window_result(drain);
                end else begin
                    second_px = window_result(drain);
                end
                n++;
            end
            col_count = 0;
            row_count = drain ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            col_count = c + 1;
        end
        if (n == 1) begin
            first_px.run_last = 1'b1;
            expected_px.push_back(first_px);
        end else if (n == 2) begin
            second_px.run_last = 1'b1;
            expected_px.push_back(first_px);
            expected_px.push_back(second_px);
        end
    endtask

    always @(posedge aclk) begin : watch
        smooth_px_t want;
        if (!aresetn) begin
            cfg_width  = FRAME_WIDTH_RST;
            cfg_height = FRAME_HEIGHT_RST;
            cfg_center = WEIGHT_CENTER_RST;
            cfg_edge   = WEIGHT_EDGE_RST;
            cfg_corner = WEIGHT_CORNER_RST;
            for (int i = 0; i < GB3_MAX_WIDTH; i++) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win[k][j] = '0;
                end
            end
            col_count = 0;
            row_count = 0;
            words_in  = 0;
            expected_px.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_FRAME_WIDTH:   cfg_width  = pwdata[FW_W-1:0];
                    REG_FRAME_HEIGHT:  cfg_height = pwdata[FH_W-1:0];
                    REG_WEIGHT_CENTER: cfg_center = pwdata[W_W-1:0];
                    REG_WEIGHT_EDGE:   cfg_edge   = pwdata[W_W-1:0];
                    REG_WEIGHT_CORNER: cfg_corner = pwdata[W_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_px.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h", m_tdata));
                end else begin
                    want = expected_px.pop_front();
                    check_field("filtered_x", m_tdata[SMP_W-1:0], want.fx);
                    check_field("filtered_y", m_tdata[2*SMP_W-1:SMP_W], want.fy);
                    check_field("filtered_b", m_tdata[3*SMP_W-1:2*SMP_W], want.fb);
                    check_field("frame_end", SMP_W'(m_tlast), SMP_W'(want.frame_end));
                    check_field("run_last", SMP_W'(m_tuser), SMP_W'(want.run_last));
                end
            end
            if (s_tvalid && s_tready) begin
                smooth_step(s_tuser, s_tdata);
                words_in++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = draw_gap(take_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic push_word(input logic cmd, input logic [PIX_W-1:0] smp);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        words_sent++;
        wait (words_in == words_sent);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_read_check(input logic [2:0] idx, input logic [APB_DW-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            report_mismatch($sformatf("register %0d read %h want %h", idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        apb_read_check(idx, val);
    endtask

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        return {rand_sample(), rand_sample(), rand_sample()};
    endfunction

    function automatic logic [APB_DW-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 32767;
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    // walk the predicted raster until the counters wrap to the next frame
    task automatic run_frame(input bit noisy);
        int h;
        do begin
            h = (cfg_height == 0) ? 1 : int'(cfg_height);
            if (row_count < h) begin
                if (noisy && $urandom_range(0, 15) == 0) begin
                    push_word(CMD_DRAIN, rand_pixel());
                end
                push_word(CMD_PIXEL, rand_pixel());
            end else if (noisy && $urandom_range(0, 5) == 0) begin
                push_word(CMD_PIXEL, rand_pixel());
            end else begin
                push_word(CMD_DRAIN, rand_pixel());
            end
        end while (row_count != 0 || col_count != 0);
    endtask

    task automatic test_register_defaults();
        apb_read_check(REG_FRAME_WIDTH, APB_DW'(FRAME_WIDTH_RST));
        apb_read_check(REG_FRAME_HEIGHT, APB_DW'(FRAME_HEIGHT_RST));
        apb_read_check(REG_WEIGHT_CENTER, APB_DW'(WEIGHT_CENTER_RST));
        apb_read_check(REG_WEIGHT_EDGE, APB_DW'(WEIGHT_EDGE_RST));
        apb_read_check(REG_WEIGHT_CORNER, APB_DW'(WEIGHT_CORNER_RST));
    endtask

    task automatic test_corner_samples();
        set_reg(REG_FRAME_WIDTH, 3);
        set_reg(REG_FRAME_HEIGHT, 2);
        set_reg(REG_WEIGHT_CENTER, 32767);
        set_reg(REG_WEIGHT_EDGE, 32767);
        set_reg(REG_WEIGHT_CORNER, 0);
        push_word(CMD_PIXEL, {16'h8000, 16'h7FFF, 16'h0000});
        push_word(CMD_DRAIN, {16'h1234, 16'h5678, 16'h9ABC});
        push_word(CMD_PIXEL, {16'h7FFF, 16'h8000, 16'hFFFF});
        push_word(CMD_PIXEL, {16'hFFFF, 16'h0001, 16'h8000});
        push_word(CMD_PIXEL, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        push_word(CMD_PIXEL, {16'h8000, 16'h8000, 16'h8000});
        push_word(CMD_PIXEL, {16'h0000, 16'hFFFF, 16'h5555});
        push_word(CMD_DRAIN, {PIX_W{1'b1}});
        push_word(CMD_PIXEL, {16'h7FFF, 16'h8000, 16'h7FFF});
        push_word(CMD_DRAIN, {PIX_W{1'b0}});
        hold_until_drained();
    endtask

    task automatic test_degenerate_sizes();
        set_reg(REG_FRAME_WIDTH, 0);
        set_reg(REG_FRAME_HEIGHT, 0);
        set_reg(REG_WEIGHT_CENTER, 0);
        set_reg(REG_WEIGHT_EDGE, 0);
        set_reg(REG_WEIGHT_CORNER, 32767);
        run_frame(1'b0);
        hold_until_drained();
        set_reg(REG_FRAME_WIDTH, 1);
        set_reg(REG_FRAME_HEIGHT, 3);
        set_reg(REG_WEIGHT_CENTER, 32767);
        set_reg(REG_WEIGHT_EDGE, 16384);
        run_frame(1'b0);
        hold_until_drained();
        set_reg(REG_FRAME_WIDTH, 2);
        set_reg(REG_FRAME_HEIGHT, 1);
        run_frame(1'b0);
        hold_until_drained();
    endtask

    task automatic test_mid_frame_shrink();
        set_reg(REG_FRAME_WIDTH, 30);
        set_reg(REG_FRAME_HEIGHT, 65535);
        set_reg(REG_WEIGHT_CENTER, APB_DW'(WEIGHT_CENTER_RST));
        set_reg(REG_WEIGHT_EDGE, APB_DW'(WEIGHT_EDGE_RST));
        set_reg(REG_WEIGHT_CORNER, APB_DW'(WEIGHT_CORNER_RST));
        repeat (80) push_word(CMD_PIXEL, rand_pixel());
        hold_until_drained();
        // column 20 now lies past the new width
        set_reg(REG_FRAME_WIDTH, 6);
        repeat (5) push_word(CMD_PIXEL, rand_pixel());
        hold_until_drained();
        // row 3 now lies past the new height
        set_reg(REG_FRAME_HEIGHT, 2);
        run_frame(1'b0);
        hold_until_drained();
    endtask

    task automatic test_widest_row();
        set_reg(REG_FRAME_WIDTH, 4097);
        set_reg(REG_FRAME_HEIGHT, 2);
        repeat (120) push_word(CMD_PIXEL, rand_pixel());
        hold_until_drained();
        // close the long row early
        set_reg(REG_FRAME_WIDTH, 4);
        run_frame(1'b0);
        hold_until_drained();
    endtask

    task automatic test_random_frames();
        int stop_at;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            hold_until_drained();
            if ($urandom_range(0, 7) == 0) begin
                set_reg(REG_FRAME_WIDTH, $urandom_range(13, 64));
            end else begin
                set_reg(REG_FRAME_WIDTH, $urandom_range(1, 12));
            end
            if ($urandom_range(0, 15) == 0) begin
                set_reg(REG_FRAME_HEIGHT, 0);
            end else begin
                set_reg(REG_FRAME_HEIGHT, $urandom_range(1, 5));
            end
            if ($urandom_range(0, 1) == 0) begin
                set_reg(REG_WEIGHT_CENTER, pick_weight());
            end
            if ($urandom_range(0, 1) == 0) begin
                set_reg(REG_WEIGHT_EDGE, pick_weight());
            end
            if ($urandom_range(0, 1) == 0) begin
                set_reg(REG_WEIGHT_CORNER, pick_weight());
            end
            run_frame(1'b1);
        end
        hold_until_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_register_defaults();
        test_corner_samples();
        test_degenerate_sizes();
        test_mid_frame_shrink();
        test_widest_row();
        test_random_frames();
        hold_until_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_px.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
